@@ design/bavg_pkg.sv @@
// Shared types and constants for the box-average image downscaler.
// No dependencies; the front, queue, back and top files use it by scoped names.
`default_nettype none
package bavg_pkg;

  localparam int MaxWidth    = 4096;
  localparam int HeightLimit = 4096;
  localparam int IdxW        = $clog2(MaxWidth);
  localparam int DimW        = 13;
  localparam int PosW        = 12;
  localparam int RunW        = 20;
  localparam int SumW        = 32;
  localparam int DivW        = 25;
  localparam int NumChan     = 3;
  localparam int QDepth      = 2;
  localparam int QPtrW       = $clog2(QDepth);
  localparam int QCntW       = $clog2(QDepth + 1);
  localparam int StepW       = $clog2(SumW);
  localparam int GreyMul     = 683;
  localparam int GreyShift   = 11;

  typedef enum logic [2:0] {
    RegSrcW  = 3'd0,
    RegSrcH  = 3'd1,
    RegTgtW  = 3'd2,
    RegTgtH  = 3'd3,
    RegGreyI = 3'd4,
    RegGreyF = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
  } pix_t;

  typedef struct packed {
    logic [7:0]      avg0;
    logic [7:0]      avg1;
    logic [7:0]      avg2;
    logic [PosW-1:0] out_col;
    logic [PosW-1:0] out_row;
    logic            frame_end;
  } res_t;

  // One closed column segment, handed from front to back.
  typedef struct packed {
    logic [NumChan-1:0][RunW-1:0] run;
    logic [IdxW-1:0]              idx;
    logic                         first;
    logic                         band_close;
    logic [DimW-1:0]              seg_w1;
    logic [DimW-1:0]              band_h1;
    logic [PosW-1:0]              out_col;
    logic [PosW-1:0]              out_row;
    logic                         frame_last;
    logic                         force_grey;
  } seg_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkRead,
    BkDiv,
    BkDone
  } back_state_e;

  typedef struct packed {
    logic dividing;
    logic divisor_nz;
  } back_stat_t;

endpackage
`default_nettype wire

@@ design/bavg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bavg_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ design/bavg_front.sv @@
// Front end: config registers, raster counters, Bresenham splits, run sums.
// Emits one segment request per closed column segment. Uses bavg_pkg.
`default_nettype none
module bavg_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [2:0]            cfg_idx_i,
  input  wire logic [12:0]           cfg_data_i,
  input  wire logic                  accept_i,
  input  wire bavg_pkg::pix_t        pix_i,
  output logic                       seg_push_o,
  output bavg_pkg::seg_t             seg_o
);

  localparam int DW = bavg_pkg::DimW;
  localparam int PW = bavg_pkg::PosW;
  localparam int RW = bavg_pkg::RunW;

  logic [DW-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
  logic          grey_i_q, grey_f_q;

  logic [PW-1:0] in_col_q, in_col_d, in_row_q, in_row_d;
  logic [DW-1:0] col_err_q, col_err_d, row_err_q, row_err_d;
  logic [DW-1:0] seg_w_q, seg_w_d, band_h_q, band_h_d;
  logic [PW-1:0] dst_col_q, dst_col_d, dst_row_q, dst_row_d;
  logic [bavg_pkg::NumChan-1:0][RW-1:0] run_q, run_d, run_new;

  logic [DW-1:0] sw, sh, tw, th;
  logic [DW-1:0] col_nx, row_nx;
  logic [DW:0]   cerr_sum, rerr_sum;
  logic          row_last, frame_last, band_close, col_close, row_end;
  logic [7:0]    pa, pb, pc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= DW'(1);
      src_h_q  <= DW'(1);
      tgt_w_q  <= DW'(1);
      tgt_h_q  <= DW'(1);
      grey_i_q <= 1'b0;
      grey_f_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bavg_pkg::RegSrcW:  src_w_q  <= cfg_data_i;
        bavg_pkg::RegSrcH:  src_h_q  <= cfg_data_i;
        bavg_pkg::RegTgtW:  tgt_w_q  <= cfg_data_i;
        bavg_pkg::RegTgtH:  tgt_h_q  <= cfg_data_i;
        bavg_pkg::RegGreyI: grey_i_q <= cfg_data_i[0];
        bavg_pkg::RegGreyF: grey_f_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // clamp the sizes into their legal ranges
    if (src_w_q == '0) sw = DW'(1);
    else if (src_w_q > DW'(bavg_pkg::MaxWidth)) sw = DW'(bavg_pkg::MaxWidth);
    else sw = src_w_q;
    if (src_h_q == '0) sh = DW'(1);
    else if (src_h_q > DW'(bavg_pkg::HeightLimit)) sh = DW'(bavg_pkg::HeightLimit);
    else sh = src_h_q;
    if (tgt_w_q == '0) tw = DW'(1);
    else if (tgt_w_q > sw) tw = sw;
    else tw = tgt_w_q;
    if (tgt_h_q == '0) th = DW'(1);
    else if (tgt_h_q > sh) th = sh;
    else th = tgt_h_q;

    pa = pix_i.chan0;
    pb = grey_i_q ? pix_i.chan0 : pix_i.chan1;
    pc = grey_i_q ? pix_i.chan0 : pix_i.chan2;
    run_new[0] = run_q[0] + RW'(pa);
    run_new[1] = run_q[1] + RW'(pb);
    run_new[2] = run_q[2] + RW'(pc);

    col_nx     = {1'b0, in_col_q} + DW'(1);
    row_nx     = {1'b0, in_row_q} + DW'(1);
    row_last   = col_nx >= sw;
    row_end    = row_nx >= sh;
    frame_last = row_last && row_end;
    rerr_sum   = {1'b0, row_err_q} + {1'b0, th};
    band_close = (rerr_sum >= {1'b0, sh}) || row_end;
    cerr_sum   = {1'b0, col_err_q} + {1'b0, tw};
    col_close  = (cerr_sum >= {1'b0, sw}) || row_last;

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    col_err_d = col_err_q;
    row_err_d = row_err_q;
    seg_w_d   = seg_w_q;
    band_h_d  = band_h_q;
    dst_col_d = dst_col_q;
    dst_row_d = dst_row_q;
    run_d     = run_q;

    if (accept_i) begin
      if (col_close) begin
        col_err_d = row_last ? '0 : DW'(cerr_sum - {1'b0, sw});
        run_d     = '0;
        seg_w_d   = '0;
        dst_col_d = dst_col_q + PW'(1);
      end else begin
        col_err_d = DW'(cerr_sum);
        run_d     = run_new;
        seg_w_d   = seg_w_q + DW'(1);
      end
      if (row_last) begin
        in_col_d  = '0;
        dst_col_d = '0;
        if (frame_last) begin
          in_row_d  = '0;
          dst_row_d = '0;
          row_err_d = '0;
          band_h_d  = '0;
        end else begin
          in_row_d = in_row_q + PW'(1);
          if (band_close) begin
            row_err_d = DW'(rerr_sum - {1'b0, sh});
            band_h_d  = '0;
            dst_row_d = dst_row_q + PW'(1);
          end else begin
            row_err_d = DW'(rerr_sum);
            band_h_d  = band_h_q + DW'(1);
          end
        end
      end else begin
        in_col_d = in_col_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      col_err_q <= '0;
      row_err_q <= '0;
      seg_w_q   <= '0;
      band_h_q  <= '0;
      dst_col_q <= '0;
      dst_row_q <= '0;
      run_q     <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      col_err_q <= col_err_d;
      row_err_q <= row_err_d;
      seg_w_q   <= seg_w_d;
      band_h_q  <= band_h_d;
      dst_col_q <= dst_col_d;
      dst_row_q <= dst_row_d;
      run_q     <= run_d;
    end
  end

  assign seg_push_o       = accept_i && col_close;
  assign seg_o.run        = run_new;
  assign seg_o.idx        = dst_col_q[bavg_pkg::IdxW-1:0];
  assign seg_o.first      = (band_h_q == '0);
  assign seg_o.band_close = band_close;
  assign seg_o.seg_w1     = seg_w_q + DW'(1);
  assign seg_o.band_h1    = band_h_q + DW'(1);
  assign seg_o.out_col    = dst_col_q;
  assign seg_o.out_row    = dst_row_q;
  assign seg_o.frame_last = frame_last;
  assign seg_o.force_grey = grey_f_q;

endmodule
`default_nettype wire

@@ design/bavg_queue.sv @@
// Short register queue of segment requests between front and back.
// Uses bavg_pkg.
`default_nettype none
module bavg_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bavg_pkg::seg_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output bavg_pkg::seg_t      data_o
);

  bavg_pkg::seg_t                 ent_q [bavg_pkg::QDepth];
  logic [bavg_pkg::QPtrW-1:0]     wp_q, rp_q;
  logic [bavg_pkg::QCntW-1:0]     cnt_q;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == bavg_pkg::QCntW'(bavg_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + bavg_pkg::QPtrW'(1);
      if (do_pop)  rp_q <= rp_q + bavg_pkg::QPtrW'(1);
      cnt_q <= cnt_q + bavg_pkg::QCntW'(do_push) - bavg_pkg::QCntW'(do_pop);
    end
  end

endmodule
`default_nettype wire

@@ design/bavg_back.sv @@
// Back end: line store update, block mean by serial division, grey mix,
// result register. Uses bavg_pkg and bavg_ram.
`default_nettype none
module bavg_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_empty_i,
  input  wire bavg_pkg::seg_t       q_data_i,
  output logic                      q_pop_o,
  output logic                      empty_o,
  input  wire logic                 pop_i,
  output bavg_pkg::res_t            res_o,
  output bavg_pkg::back_stat_t      stat_o
);

  localparam int NC = bavg_pkg::NumChan;
  localparam int SW = bavg_pkg::SumW;
  localparam int VW = bavg_pkg::DivW;

  bavg_pkg::back_state_e state_q, state_d;
  bavg_pkg::seg_t        rec_q;
  logic [NC-1:0][SW-1:0] rd_data, tot;
  logic [SW-1:0]         dvd_q [NC];
  logic [VW-1:0]         rem_q [NC];
  logic [VW-1:0]         div_q;
  logic [bavg_pkg::StepW-1:0] step_q;
  bavg_pkg::res_t        out_q;
  logic                  out_vld_q;
  logic                  ram_we, ram_re, load_out, out_take;
  logic [9:0]            grey_sum;
  logic [19:0]           grey_prod;
  logic [7:0]            q0, q1, q2, grey;

  bavg_ram #(
    .Width (NC * SW),
    .Depth (bavg_pkg::MaxWidth)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (rec_q.idx),
    .wdata_i (tot),
    .re_i    (ram_re),
    .raddr_i (q_data_i.idx),
    .rdata_o (rd_data)
  );

  for (genvar c = 0; c < NC; c++) begin : g_tot
    assign tot[c] = (rec_q.first ? '0 : rd_data[c]) + SW'(rec_q.run[c]);
  end

  assign out_take = out_vld_q && pop_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bavg_pkg::BkIdle: if (!q_empty_i) state_d = bavg_pkg::BkRead;
      bavg_pkg::BkRead: state_d = rec_q.band_close ? bavg_pkg::BkDiv : bavg_pkg::BkIdle;
      bavg_pkg::BkDiv:  if (step_q == bavg_pkg::StepW'(SW - 1)) state_d = bavg_pkg::BkDone;
      bavg_pkg::BkDone: if (!out_vld_q || out_take) state_d = bavg_pkg::BkIdle;
      default:          state_d = bavg_pkg::BkIdle;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      bavg_pkg::BkIdle: begin
        q_pop_o = !q_empty_i;
        ram_re  = !q_empty_i;
      end
      bavg_pkg::BkRead: ram_we = !rec_q.band_close;
      bavg_pkg::BkDiv:  ;
      bavg_pkg::BkDone: load_out = !out_vld_q || out_take;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bavg_pkg::BkIdle;
      out_vld_q <= 1'b0;
      step_q    <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) out_vld_q <= 1'b1;
      else if (out_take) out_vld_q <= 1'b0;
      if (state_q == bavg_pkg::BkDiv) step_q <= step_q + bavg_pkg::StepW'(1);
      else step_q <= '0;
    end
  end

  // restoring division, one quotient bit per cycle in each lane
  always_ff @(posedge clk_i) begin
    logic [VW:0] shl;
    if (q_pop_o) rec_q <= q_data_i;
    if (state_q == bavg_pkg::BkRead) begin
      div_q <= VW'(rec_q.seg_w1 * rec_q.band_h1);
    end
    for (int c = 0; c < NC; c++) begin
      if (state_q == bavg_pkg::BkRead) begin
        dvd_q[c] <= tot[c];
        rem_q[c] <= '0;
      end else if (state_q == bavg_pkg::BkDiv) begin
        shl = {rem_q[c], dvd_q[c][SW-1]};
        if (shl >= {1'b0, div_q}) begin
          rem_q[c] <= VW'(shl - {1'b0, div_q});
          dvd_q[c] <= {dvd_q[c][SW-2:0], 1'b1};
        end else begin
          rem_q[c] <= VW'(shl);
          dvd_q[c] <= {dvd_q[c][SW-2:0], 1'b0};
        end
      end
    end
    if (load_out) begin
      out_q.avg0      <= rec_q.force_grey ? grey : q0;
      out_q.avg1      <= rec_q.force_grey ? grey : q1;
      out_q.avg2      <= rec_q.force_grey ? grey : q2;
      out_q.out_col   <= rec_q.out_col;
      out_q.out_row   <= rec_q.out_row;
      out_q.frame_end <= rec_q.frame_last;
    end
  end

  // divide the channel sum by three through a reciprocal multiply
  assign q0        = dvd_q[0][7:0];
  assign q1        = dvd_q[1][7:0];
  assign q2        = dvd_q[2][7:0];
  assign grey_sum  = 10'(q0) + 10'(q1) + 10'(q2);
  assign grey_prod = 20'(grey_sum) * 20'(bavg_pkg::GreyMul);
  assign grey      = grey_prod[bavg_pkg::GreyShift +: 8];

  assign empty_o           = !out_vld_q;
  assign res_o             = out_q;
  assign stat_o.dividing   = (state_q == bavg_pkg::BkDiv);
  assign stat_o.divisor_nz = (div_q != '0);

endmodule
`default_nettype wire

@@ design/box_average_image_downscaler.sv @@
// Box-average image downscaler top level: front, segment queue, back.
// Accepts one pixel per cycle while the segment queue has room. A closed segment
// passes the back end through its idle and read states, and, when it completes an output
// pixel, also through the serial divider and a done state that waits for the result register.
// Reset clears counters, errors and sums; the line store needs no clearing.
`default_nettype none
module box_average_image_downscaler (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [2:0]     cfg_idx_i,
  input  wire logic [12:0]    cfg_data_i,
  input  wire logic           push,
  output logic                full,
  input  wire bavg_pkg::pix_t in_data_i,
  output logic                empty,
  input  wire logic           pop,
  output bavg_pkg::res_t      out_data_o
);

  logic                 seg_push, q_full, q_empty, q_pop;
  bavg_pkg::seg_t       seg_in, seg_out;
  bavg_pkg::back_stat_t bk_stat;

  assign full = q_full;

  bavg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (push && !q_full),
    .pix_i      (in_data_i),
    .seg_push_o (seg_push),
    .seg_o      (seg_in)
  );

  bavg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (seg_push),
    .data_i  (seg_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (seg_out)
  );

  bavg_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (seg_out),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .res_o     (out_data_o),
    .stat_o    (bk_stat)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(seg_push && q_full)) else $error("segment request pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("segment request popped from empty queue");

  a_div_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.dividing |-> bk_stat.divisor_nz) else $error("division by zero");

endmodule
`default_nettype wire
